// ===== rtl/ctf_pkg.sv =====
// Shared types, constants and the arctangent table of the complementary tilt filter.
package ctf_pkg;

   // CORDIC iteration count and arctangent table geometry
   localparam int CTF_CORDIC_STEPS = 16;
   localparam int CTF_ATAN_LEN     = 24;
   localparam int CTF_ITER_LIMIT   = (CTF_CORDIC_STEPS < CTF_ATAN_LEN) ?
                                     CTF_CORDIC_STEPS : CTF_ATAN_LEN;
   localparam int CTF_STEP_W       = $clog2(CTF_ITER_LIMIT + 1);
   localparam int CTF_ATAN_IDX_W   = $clog2(CTF_ATAN_LEN);

   // Angle limits in 1/128 degree
   localparam logic signed [15:0] CTF_ANG_MAX = 16'sd23040;
   localparam logic signed [15:0] CTF_ANG_MIN = -16'sd23040;

   // Half turn in Q16 degrees
   localparam logic signed [26:0] CTF_Z_HALF_TURN = 27'sd11796480;

   // Gyro scale divisor: 32.8 LSB per deg/s over ms, 1/128 degree out
   localparam logic signed [15:0] CTF_DIV_K = 16'sd1025;

   // Reset value of the gyro weight (0.98 in Q0.16)
   localparam logic [15:0] CTF_WEIGHT_RST = 16'd64225;

   typedef logic signed [15:0] angle_type;
   typedef logic signed [16:0] cordic_in_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GYRO_MUL,
      ST_GYRO_ABS,
      ST_DIV_EST,
      ST_DIV_REM,
      ST_DIV_FIX,
      ST_TILT_WAIT,
      ST_WEIGHT_MUL,
      ST_ACCEL_MUL,
      ST_BLEND
   } ctf_state_type;

   // atan(2^-i) in degrees, Q16
   function automatic logic [21:0] ctf_atan_q16(input logic [CTF_ATAN_IDX_W-1:0] idx);
      logic [21:0] val;
      case (idx)
         5'd0:    val = 22'd2949120;
         5'd1:    val = 22'd1740967;
         5'd2:    val = 22'd919879;
         5'd3:    val = 22'd466945;
         5'd4:    val = 22'd234379;
         5'd5:    val = 22'd117304;
         5'd6:    val = 22'd58665;
         5'd7:    val = 22'd29335;
         5'd8:    val = 22'd14668;
         5'd9:    val = 22'd7334;
         5'd10:   val = 22'd3667;
         5'd11:   val = 22'd1833;
         5'd12:   val = 22'd917;
         5'd13:   val = 22'd458;
         5'd14:   val = 22'd229;
         5'd15:   val = 22'd115;
         5'd16:   val = 22'd57;
         5'd17:   val = 22'd29;
         5'd18:   val = 22'd14;
         5'd19:   val = 22'd7;
         5'd20:   val = 22'd4;
         5'd21:   val = 22'd2;
         5'd22:   val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/ctf_cordic.sv =====
// Iterative vectoring CORDIC computing atan2(y, x) in 1/128 degree, one rotation a cycle.
module ctf_cordic (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ctf_pkg::cordic_in_type vec_y,
   input  ctf_pkg::cordic_in_type vec_x,
   output logic                  busy,
   output ctf_pkg::angle_type    angle
);
   import ctf_pkg::*;

   logic signed [35:0]     x_ff, x_in;
   logic signed [35:0]     y_ff, y_in;
   logic signed [26:0]     z_ff, z_in;
   logic [CTF_STEP_W-1:0]  step_ff, step_in;
   logic                   busy_ff, busy_in;

   logic                   x_neg;
   cordic_in_type          x_start;
   cordic_in_type          y_start;
   logic signed [26:0]     z_start;
   logic signed [35:0]     x_shr;
   logic signed [35:0]     y_shr;
   logic signed [26:0]     atan_step;
   logic                   last_step;
   logic signed [26:0]     z_round;
   logic signed [26:0]     z_scaled;

   // Fold the left half-plane onto the right one
   assign x_neg   = vec_x[16];
   assign x_start = x_neg ? -vec_x : vec_x;
   assign y_start = x_neg ? -vec_y : vec_y;
   assign z_start = !x_neg ? 27'sd0 : (vec_y[16] ? -CTF_Z_HALF_TURN : CTF_Z_HALF_TURN);

   // Shift terms and table angle for the current rotation
   assign x_shr     = x_ff >>> step_ff;
   assign y_shr     = y_ff >>> step_ff;
   assign atan_step = $signed({5'b00000, ctf_atan_q16(CTF_ATAN_IDX_W'(step_ff))});
   assign last_step = (y_ff == 36'sd0) || (step_ff == CTF_STEP_W'(CTF_ITER_LIMIT));

   // Load on start, rotate towards the x axis while busy
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in    = {{3{x_start[16]}}, x_start, 16'h0000};
         y_in    = {{3{y_start[16]}}, y_start, 16'h0000};
         z_in    = z_start;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (last_step) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
            if (y_ff > 36'sd0) begin
               x_in = x_ff + y_shr;
               y_in = y_ff - x_shr;
               z_in = z_ff + atan_step;
            end else begin
               x_in = x_ff - y_shr;
               y_in = y_ff + x_shr;
               z_in = z_ff - atan_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
   end

   // Round to 1/128 degree and saturate to a half turn
   assign z_round  = z_ff + 27'sd256;
   assign z_scaled = z_round >>> 9;

   always_comb begin
      if (z_scaled > 27'(CTF_ANG_MAX)) begin
         angle = CTF_ANG_MAX;
      end else if (z_scaled < 27'(CTF_ANG_MIN)) begin
         angle = CTF_ANG_MIN;
      end else begin
         angle = z_scaled[15:0];
      end
   end

   assign busy = busy_ff;

endmodule

// ===== rtl/imu_complementary_tilt_filter.sv =====
// Each accepted transaction yields a result for roll then pitch, one axis after the other.
// The CORDIC unit and the shared 18x25 multiplier serve both axes in turn.
// A new transaction is taken only after the previous result is stored; the result waits in
// an output register, so the next transaction is taken meanwhile.
// Reset (synchronous, active high) clears both angle estimates to zero and loads
// the gyro weight with 0.98 (64225 in Q0.16).
module imu_complementary_tilt_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic [15:0] req_elapsed_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ctf_pkg::angle_type rsp_roll_angle,
   output ctf_pkg::angle_type rsp_pitch_angle,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);
   import ctf_pkg::*;

   ctf_state_type      state_ff, state_in;
   logic               axis_ff, axis_in;

   logic signed [15:0] accel_x_ff, accel_x_in;
   logic signed [15:0] accel_y_ff, accel_y_in;
   logic signed [15:0] accel_z_ff, accel_z_in;
   logic signed [15:0] gyro_x_ff, gyro_x_in;
   logic signed [15:0] gyro_y_ff, gyro_y_in;
   logic [15:0]        elapsed_ms_ff, elapsed_ms_in;

   logic [15:0]        gyro_weight_ff, gyro_weight_in;
   angle_type          roll_est_ff, roll_est_in;
   angle_type          pitch_est_ff, pitch_est_in;

   logic signed [42:0] prod_ff, prod_in;
   logic signed [42:0] sum_ff, sum_in;
   logic [33:0]        div_ff, div_in;
   logic               neg_ff, neg_in;
   logic [23:0]        quo_ff, quo_in;
   logic signed [15:0] rem_ff, rem_in;
   logic signed [24:0] inc_ff, inc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   angle_type          rsp_roll_ff, rsp_roll_in;
   angle_type          rsp_pitch_ff, rsp_pitch_in;

   // Control decoded from the state
   logic               accept;
   logic               cordic_start;
   logic               prod_load;
   logic               out_free;
   logic               rem_low;
   logic               rem_high;

   // Shared multiplier
   logic signed [17:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [42:0] mul_p;

   // Axis selection and datapath intermediates
   logic signed [15:0] gyro_sel;
   angle_type          est_sel;
   cordic_in_type      cordic_y;
   cordic_in_type      cordic_x;
   logic               cordic_busy;
   angle_type          tilt_angle;
   logic signed [17:0] accel_weight;
   logic signed [24:0] propagated;
   logic signed [42:0] prod_mag;
   logic [33:0]        rem_full;
   logic signed [43:0] blend_sum;
   logic signed [27:0] blend_shr;
   angle_type          blend_angle;

   // Select the operands of the axis in work
   assign gyro_sel = axis_ff ? gyro_y_ff : gyro_x_ff;
   assign est_sel  = axis_ff ? pitch_est_ff : roll_est_ff;
   assign cordic_y = axis_ff ? -{accel_x_ff[15], accel_x_ff} : {accel_y_ff[15], accel_y_ff};
   assign cordic_x = {accel_z_ff[15], accel_z_ff};

   ctf_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .vec_y (cordic_y),
      .vec_x (cordic_x),
      .busy  (cordic_busy),
      .angle (tilt_angle)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rem_low  = rem_ff < 16'sd0;
   assign rem_high = rem_ff >= CTF_DIV_K;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_GYRO_MUL;
         ST_GYRO_MUL:   state_in = ST_GYRO_ABS;
         ST_GYRO_ABS:   state_in = ST_DIV_EST;
         ST_DIV_EST:    state_in = ST_DIV_REM;
         ST_DIV_REM:    state_in = ST_DIV_FIX;
         ST_DIV_FIX:    if (!rem_low && !rem_high) state_in = ST_TILT_WAIT;
         ST_TILT_WAIT:  if (!cordic_busy) state_in = ST_WEIGHT_MUL;
         ST_WEIGHT_MUL: state_in = ST_ACCEL_MUL;
         ST_ACCEL_MUL:  state_in = ST_BLEND;
         ST_BLEND: begin
            if (!axis_ff) begin
               state_in = ST_GYRO_MUL;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // State outputs: handshake, unit start and multiplier operands
   assign accel_weight = 18'sd65536 - $signed({2'b00, gyro_weight_ff});
   assign propagated   = {{9{est_sel[15]}}, est_sel} + inc_ff;

   always_comb begin
      req_ready    = 1'b0;
      cordic_start = 1'b0;
      prod_load    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_GYRO_MUL: begin
            cordic_start = 1'b1;
            prod_load    = 1'b1;
            mul_a        = {{2{gyro_sel[15]}}, gyro_sel};
            mul_b        = $signed({9'h000, elapsed_ms_ff});
         end
         ST_WEIGHT_MUL: begin
            prod_load = 1'b1;
            mul_a     = $signed({2'b00, gyro_weight_ff});
            mul_b     = propagated;
         end
         ST_ACCEL_MUL: begin
            prod_load = 1'b1;
            mul_a     = accel_weight;
            mul_b     = {{9{tilt_angle[15]}}, tilt_angle};
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;
   assign mul_p  = mul_a * mul_b;

   // Magnitude of the gyro product, and the remainder of the quotient estimate by 1025
   assign prod_mag = prod_ff[42] ? -prod_ff : prod_ff;
   assign rem_full = div_ff - {quo_ff, 10'h000} - {10'h000, quo_ff};

   // Blend sum, round half up, saturate
   assign blend_sum = {sum_ff[42], sum_ff} + {prod_ff[42], prod_ff} + 44'sd32768;
   assign blend_shr = blend_sum[43:16];

   always_comb begin
      if (blend_shr > 28'(CTF_ANG_MAX)) begin
         blend_angle = CTF_ANG_MAX;
      end else if (blend_shr < 28'(CTF_ANG_MIN)) begin
         blend_angle = CTF_ANG_MIN;
      end else begin
         blend_angle = blend_shr[15:0];
      end
   end

   // Datapath next values
   always_comb begin
      axis_in        = axis_ff;
      accel_x_in     = accel_x_ff;
      accel_y_in     = accel_y_ff;
      accel_z_in     = accel_z_ff;
      gyro_x_in      = gyro_x_ff;
      gyro_y_in      = gyro_y_ff;
      elapsed_ms_in  = elapsed_ms_ff;
      gyro_weight_in = gyro_weight_ff;
      roll_est_in    = roll_est_ff;
      pitch_est_in   = pitch_est_ff;
      prod_in        = prod_ff;
      sum_in         = sum_ff;
      div_in         = div_ff;
      neg_in         = neg_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      inc_in         = inc_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_roll_in    = rsp_roll_ff;
      rsp_pitch_in   = rsp_pitch_ff;

      // Capture the transaction
      if (accept) begin
         axis_in       = 1'b0;
         accel_x_in    = req_accel_x;
         accel_y_in    = req_accel_y;
         accel_z_in    = req_accel_z;
         gyro_x_in     = req_gyro_x;
         gyro_y_in     = req_gyro_y;
         elapsed_ms_in = req_elapsed_ms;
      end

      if (csr_write_en) begin
         gyro_weight_in = csr_write_data;
      end

      if (prod_load) begin
         prod_in = mul_p;
      end

      case (state_ff)
         ST_GYRO_ABS: begin
            neg_in = prod_ff[42];
            div_in = {prod_mag[30:0], 2'b00} + 34'd512;
         end
         // Estimate the quotient by 1025 from the series 1/1024 - 1/1024^2 + 1/1024^3
         ST_DIV_EST: begin
            quo_in = div_ff[33:10] - {10'h000, div_ff[33:20]} + {20'h00000, div_ff[33:30]};
         end
         ST_DIV_REM: begin
            rem_in = $signed(rem_full[15:0]);
         end
         // Step the quotient until the remainder lies in range
         ST_DIV_FIX: begin
            if (rem_low) begin
               quo_in = quo_ff - 24'd1;
               rem_in = rem_ff + CTF_DIV_K;
            end else if (rem_high) begin
               quo_in = quo_ff + 24'd1;
               rem_in = rem_ff - CTF_DIV_K;
            end else begin
               inc_in = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
            end
         end
         ST_ACCEL_MUL: begin
            sum_in = prod_ff;
         end
         // Store the roll estimate, or the pitch estimate with the result
         ST_BLEND: begin
            if (!axis_ff) begin
               roll_est_in = blend_angle;
               axis_in     = 1'b1;
            end else if (out_free) begin
               pitch_est_in = blend_angle;
               rsp_valid_in = 1'b1;
               rsp_roll_in  = roll_est_ff;
               rsp_pitch_in = blend_angle;
            end
         end
         default: begin
            neg_in = neg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         gyro_weight_ff <= CTF_WEIGHT_RST;
         roll_est_ff    <= '0;
         pitch_est_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         gyro_weight_ff <= gyro_weight_in;
         roll_est_ff    <= roll_est_in;
         pitch_est_ff   <= pitch_est_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      axis_ff       <= axis_in;
      accel_x_ff    <= accel_x_in;
      accel_y_ff    <= accel_y_in;
      accel_z_ff    <= accel_z_in;
      gyro_x_ff     <= gyro_x_in;
      gyro_y_ff     <= gyro_y_in;
      elapsed_ms_ff <= elapsed_ms_in;
      prod_ff       <= prod_in;
      sum_ff        <= sum_in;
      div_ff        <= div_in;
      neg_ff        <= neg_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      inc_ff        <= inc_in;
      rsp_roll_ff   <= rsp_roll_in;
      rsp_pitch_ff  <= rsp_pitch_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = rsp_roll_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the complementary tilt filter.
`timescale 1ns / 1ps

module tb_top;
   import ctf_pkg::*;

   localparam int REQ_IDLE_MAX  = 12;
   localparam int RSP_IDLE_MAX  = 12;
   localparam int SETTLE_CYCLES = 60;
   localparam int STALL_LIMIT   = 4000;
   localparam int CHUNK_LEN     = 40;
   localparam int PHASE_LEN     = 280;
   localparam int PRINT_CAP     = 50;

   typedef struct {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] gx;
      logic signed [15:0] gy;
      logic [15:0]        ms;
   } imu_sample_type;

   typedef struct {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
   } tilt_pair_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_accel_x = '0;
   logic signed [15:0] req_accel_y = '0;
   logic signed [15:0] req_accel_z = '0;
   logic signed [15:0] req_gyro_x = '0;
   logic signed [15:0] req_gyro_y = '0;
   logic [15:0]        req_elapsed_ms = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   angle_type          rsp_roll_angle;
   angle_type          rsp_pitch_angle;
   logic               csr_write_en = 1'b0;
   logic [15:0]        csr_write_data = '0;

   // Samples waiting to be sent, and filtered angles still to arrive
   imu_sample_type     sample_q[$];
   tilt_pair_type      tilt_due_q[$];

   // Shadow of the filter state and of the weight register
   logic [15:0]        weight_shadow = CTF_WEIGHT_RST;
   logic signed [15:0] roll_est = '0;
   logic signed [15:0] pitch_est = '0;

   // atan(2^-i) in Q16 degrees
   longint             atan_step_q16 [0:23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58665, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   bit                 req_taken = 1'b0;
   bit                 rsp_taken = 1'b0;
   int                 req_idle_left = 0;
   int                 rsp_idle_left = 0;
   int                 req_gap_max = REQ_IDLE_MAX;
   int                 rsp_gap_max = RSP_IDLE_MAX;
   int                 quiet_cycles = 0;
   int                 fault_count = 0;

   imu_complementary_tilt_filter u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .req_gyro_x      (req_gyro_x),
      .req_gyro_y      (req_gyro_y),
      .req_elapsed_ms  (req_elapsed_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_pitch_angle (rsp_pitch_angle),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Vectoring CORDIC: atan2(y, x) in 1/128 degree, saturated to a half turn
   function automatic longint tilt_angle(input longint y_in, input longint x_in);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      longint r;
      int     i;
      x = x_in;
      y = y_in;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
         x = -x;
         y = -y;
      end
      x = x * 65536;
      y = y * 65536;
      for (i = 0; i < CTF_ITER_LIMIT; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y == 0) break;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_step_q16[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_step_q16[i];
         end
      end
      r = (z + 256) >>> 9;
      if (r > 23040) r = 23040;
      if (r < -23040) r = -23040;
      return r;
   endfunction

   // Gyro counts times ms to 1/128 degree, rounded half away from zero
   function automatic longint gyro_step(input longint rate, input longint ms);
      longint n;
      longint m;
      longint q;
      n = rate * ms * 4;
      m = (n < 0) ? -n : n;
      q = (m + 512) / 1025;
      return (n < 0) ? -q : q;
   endfunction

   function automatic logic signed [15:0] mix_angle(input longint est, input longint inc,
                                                    input longint acc, input longint w);
      longint s;
      longint r;
      s = w * (est + inc) + (65536 - w) * acc;
      r = (s + 32768) >>> 16;
      if (r > 23040) r = 23040;
      if (r < -23040) r = -23040;
      return 16'(r);
   endfunction

   // Advance the shadow estimates by one sample and return the new angles
   function automatic tilt_pair_type advance_tilt(input imu_sample_type s);
      tilt_pair_type t;
      longint        w;
      w = longint'(weight_shadow);
      t.roll  = mix_angle(longint'(roll_est), gyro_step(longint'(s.gx), longint'(s.ms)),
                          tilt_angle(longint'(s.ay), longint'(s.az)), w);
      t.pitch = mix_angle(longint'(pitch_est), gyro_step(longint'(s.gy), longint'(s.ms)),
                          tilt_angle(-longint'(s.ax), longint'(s.az)), w);
      roll_est  = t.roll;
      pitch_est = t.pitch;
      return t;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (fault_count < PRINT_CAP)
         $display("%0t ns: %s got %0d, want %0d", $time, what, got, want);
      fault_count++;
   endtask

   // Sample handshakes, predict on accepted requests, check accepted responses
   always @(posedge clock) begin : monitor
      tilt_pair_type due;
      req_taken = !reset && req_valid && req_ready;
      rsp_taken = !reset && rsp_valid && rsp_ready;
      if (reset) begin
         weight_shadow = CTF_WEIGHT_RST;
         roll_est      = '0;
         pitch_est     = '0;
      end else if (csr_write_en) begin
         weight_shadow = csr_write_data;
      end
      if (req_taken)
         tilt_due_q.push_back(advance_tilt(sample_q[0]));
      if (rsp_taken) begin
         if (tilt_due_q.size() == 0) begin
            report_mismatch("unexpected transaction, roll", rsp_roll_angle, 0);
         end else begin
            due = tilt_due_q.pop_front();
            if (rsp_roll_angle !== due.roll)
               report_mismatch("roll_angle", rsp_roll_angle, due.roll);
            if (rsp_pitch_angle !== due.pitch)
               report_mismatch("pitch_angle", rsp_pitch_angle, due.pitch);
         end
      end
      // Watchdog on stalled traffic
      if (req_taken || rsp_taken || reset) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Request driver: hold a pending transaction, otherwise idle or present the next sample
   always @(negedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken) begin
            sample_q.delete(0);
            req_idle_left = $urandom_range(0, req_gap_max);
         end
         if (!(req_valid && !req_taken)) begin
            if (req_idle_left > 0) begin
               req_idle_left--;
               req_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
               req_accel_x    <= sample_q[0].ax;
               req_accel_y    <= sample_q[0].ay;
               req_accel_z    <= sample_q[0].az;
               req_gyro_x     <= sample_q[0].gx;
               req_gyro_y     <= sample_q[0].gy;
               req_elapsed_ms <= sample_q[0].ms;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response sink: stall a random number of cycles after each transaction
   always @(negedge clock) begin : sink
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken) rsp_idle_left = $urandom_range(0, rsp_gap_max);
         if (rsp_idle_left > 0) begin
            rsp_idle_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic imu_sample_type make_sample(input int ax, input int ay, input int az,
                                                  input int gx, input int gy, input int ms);
      imu_sample_type s;
      s.ax = 16'(ax);
      s.ay = 16'(ay);
      s.az = 16'(az);
      s.gx = 16'(gx);
      s.gy = 16'(gy);
      s.ms = 16'(ms);
      return s;
   endfunction

   // Mostly plausible motion, with raw noise and on-axis vectors mixed in
   function automatic imu_sample_type random_sample();
      imu_sample_type s;
      int unsigned    mode;
      mode = $urandom_range(0, 9);
      s = make_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      if (mode <= 5) begin
         s.ax = 16'(int'($urandom_range(0, 40000)) - 20000);
         s.ay = 16'(int'($urandom_range(0, 40000)) - 20000);
         s.az = 16'(int'($urandom_range(0, 40000)) - 20000);
         s.gx = 16'(int'($urandom_range(0, 8000)) - 4000);
         s.gy = 16'(int'($urandom_range(0, 8000)) - 4000);
         s.ms = 16'($urandom_range(0, 40));
      end else if (mode == 8) begin
         if ($urandom_range(0, 1)) s.ay = '0;
         else s.ax = '0;
         if ($urandom_range(0, 3) == 0) s.az = '0;
      end else if (mode == 9) begin
         s.ms = 16'($urandom_range(0, 255));
      end
      return s;
   endfunction

   // Wait until every sample is sent and every angle has arrived, then let the block settle
   task automatic drain();
      while (sample_q.size() != 0 || req_valid || tilt_due_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_weight(input logic [15:0] w);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= w;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   task automatic pick_idle_mode();
      int unsigned sel;
      sel = $urandom_range(0, 3);
      req_gap_max = (sel == 0) ? 0 : (sel == 1) ? 3 : REQ_IDLE_MAX;
      sel = $urandom_range(0, 3);
      rsp_gap_max = (sel == 0) ? 0 : (sel == 1) ? 3 : RSP_IDLE_MAX;
   endtask

   task automatic run_phase(input logic [15:0] w, input int count);
      int sent;
      int i;
      drain();
      write_weight(w);
      sent = 0;
      while (sent < count) begin
         pick_idle_mode();
         for (i = 0; i < CHUNK_LEN && sent < count; i++) begin
            sample_q.push_back(random_sample());
            sent++;
         end
         // Now and then let the pipeline run dry before going on
         if ($urandom_range(0, 3) == 0) drain();
         else while (sample_q.size() > 4) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_weight(CTF_WEIGHT_RST);
      // Directed: zero vector, half-turn cases, exact axes, field extremes, rounding
      sample_q.push_back(make_sample(0, 0, 0, 0, 0, 0));
      sample_q.push_back(make_sample(0, 0, -1000, 0, 0, 10));
      sample_q.push_back(make_sample(0, 0, 16384, 0, 0, 10));
      sample_q.push_back(make_sample(-16384, 16384, 0, 0, 0, 10));
      sample_q.push_back(make_sample(32767, -32768, 0, 0, 0, 10));
      sample_q.push_back(make_sample(32767, 0, -32768, 0, 0, 10));
      sample_q.push_back(make_sample(-32768, 0, -1, 0, 0, 10));
      sample_q.push_back(make_sample(1, -1, -1, 1, -1, 1));
      sample_q.push_back(make_sample(0, 0, 1, 128, -128, 1));
      sample_q.push_back(make_sample(0, 0, 1, 129, -129, 1));
      sample_q.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 65535));
      sample_q.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 65535));
      sample_q.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, 65535));
      sample_q.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, 65535));
      sample_q.push_back(make_sample(-32768, 32767, -32768, -32768, 32767, 65535));
      sample_q.push_back(make_sample(32767, -32768, 32767, 0, 0, 0));
      sample_q.push_back(make_sample(-32768, 32767, 32767, 100, -100, 20));
      sample_q.push_back(make_sample(0, 1, 0, 0, 0, 1));
      sample_q.push_back(make_sample(0, -1, 0, 0, 0, 1));
      sample_q.push_back(make_sample(-1, 0, 0, 0, 0, 1));

      run_phase(16'd0, 20);
      run_phase(16'd65535, PHASE_LEN);
      run_phase(16'd0, PHASE_LEN);
      run_phase(16'd1, PHASE_LEN);
      run_phase(16'd32768, PHASE_LEN);
      run_phase(16'($urandom), PHASE_LEN);
      run_phase(CTF_WEIGHT_RST, PHASE_LEN);
      drain();

      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
